/* rtl/rgbhsv_pkg.sv */
// rgbhsv_pkg: payload types and fixed-point constants for the RGB to HSV converter.
// No dependencies; used by rgb_to_hsv_convert.

package rgbhsv_pkg;

    localparam int CH_W  = 8;   // channel byte width
    localparam int HUE_W = 15;  // hue width, 1/64 degree units
    localparam int QUO_W = 12;  // divider quotient width, covers 0..3840

    localparam int unsigned HUE_SIXTH = 3840;   // 60 degrees
    localparam int unsigned HUE_TURN  = 23040;  // 360 degrees
    localparam int unsigned SAT_SCALE = 255;

    typedef struct packed {
        logic [CH_W-1:0] red_in;
        logic [CH_W-1:0] green_in;
        logic [CH_W-1:0] blue_in;
    } pixel_t;

    typedef struct packed {
        logic [HUE_W-1:0] hue_out;
        logic [CH_W-1:0]  saturation_out;
        logic [CH_W-1:0]  value_out;
    } hsv_t;

endpackage

/* rtl/rgbhsv_div.sv */
// rgbhsv_div: pipelined unsigned restoring divider, STEP_BITS quotient bits per stage.
// No package dependency; instantiated by rgb_to_hsv_convert.

module rgbhsv_div #(
    parameter int QUO_W     = 12,
    parameter int DEN_W     = 8,
    parameter int STEP_BITS = 2
) (
    input  logic                           clk,
    input  logic [QUO_W/STEP_BITS-1:0]     en,
    input  logic [DEN_W+QUO_W-1:0]         num,
    input  logic [DEN_W-1:0]               den,
    output logic [QUO_W-1:0]               quo
);

    localparam int W      = DEN_W + QUO_W;
    localparam int STAGES = QUO_W / STEP_BITS;

    // Word layout: partial remainder on top, unconsumed dividend bits below,
    // quotient bits shift in at the bottom. Requires num < den << QUO_W.
    logic [W-1:0]     w_reg   [STAGES];
    logic [W-1:0]     w_next  [STAGES];
    logic [DEN_W-1:0] den_reg [STAGES];
    logic [DEN_W-1:0] den_next[STAGES];

    for (genvar j = 0; j < STAGES; j++) begin : g_stage
        logic [W-1:0]     w_in;
        logic [DEN_W-1:0] d_in;

        if (j == 0)
        begin : g_head
            assign w_in = num;
            assign d_in = den;
        end
        else
        begin : g_tail
            assign w_in = w_reg[j-1];
            assign d_in = den_reg[j-1];
        end

        always_comb
        begin
            logic [W-1:0]     w;
            logic [DEN_W:0]   t;
            logic             qbit;
            w           = w_in;
            den_next[j] = d_in;
            for (int s = 0; s < STEP_BITS; s++)
            begin
                t    = {w[W-1 -: DEN_W], w[QUO_W-1]};
                qbit = (t >= {1'b0, den_next[j]});
                if (qbit)
                begin
                    t = t - {1'b0, den_next[j]};
                end
                w = {t[DEN_W-1:0], w[QUO_W-2:0], qbit};
            end
            w_next[j] = w;
        end

        always_ff @(posedge clk)
        begin
            if (en[j])
            begin
                w_reg[j]   <= w_next[j];
                den_reg[j] <= den_next[j];
            end
        end
    end

    assign quo = w_reg[STAGES-1][QUO_W-1:0];

endmodule

/* rtl/rgb_to_hsv_convert.sv */
// rgb_to_hsv_convert: pipelined 8-bit RGB to fixed-point HSV converter.
// Depends on rgbhsv_pkg (types, constants) and rgbhsv_div (quotient pipelines).
//
//   channel  signals                          payload           direction
//   pixel    pixel_valid / pixel_ready        rgbhsv_pkg::pixel_t  in
//   hsv      hsv_valid   / hsv_ready          rgbhsv_pkg::hsv_t    out
//
// One pixel per clock sustained while hsv_ready stays high. Registers in order: stages 1 to 3, the stages
// of the two divider pipelines (DIV_STEP_BITS quotient bits per stage), then the output register.
// Reset clears only the stage valid bits.
// Each stage holds while its successor is full and stalled; empty stages keep filling,
// so a transaction is taken while a finished result waits in the output register, if some stage is empty.

module rgb_to_hsv_convert #(
    parameter int DIV_STEP_BITS = 2
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               pixel_valid,
    output logic               pixel_ready,
    input  rgbhsv_pkg::pixel_t pixel,
    output logic               hsv_valid,
    input  logic               hsv_ready,
    output rgbhsv_pkg::hsv_t   hsv
);

    localparam int CH_W       = rgbhsv_pkg::CH_W;
    localparam int HUE_W      = rgbhsv_pkg::HUE_W;
    localparam int QUO_W      = rgbhsv_pkg::QUO_W;
    localparam int NUM_W      = CH_W + QUO_W;
    localparam int DIV_STAGES = QUO_W / DIV_STEP_BITS;
    localparam int DIV_FIRST  = 3;
    localparam int NST        = DIV_FIRST + DIV_STAGES + 1;
    localparam int OUT_ST     = NST - 1;

    typedef enum logic [1:0] {
        SECT_RED,
        SECT_GREEN,
        SECT_BLUE
    } sector_t;

    typedef struct packed {
        logic [CH_W-1:0] mx;
        logic [CH_W-1:0] mn;
        logic [CH_W-1:0] x;   // hue difference is x - y
        logic [CH_W-1:0] y;
        sector_t         sector;
    } p1_t;

    typedef struct packed {
        logic [CH_W-1:0] delta;
        logic [CH_W-1:0] mag;
        logic            neg;
        sector_t         sector;
        logic [CH_W-1:0] mx;
        logic            black;
    } p2_t;

    typedef struct packed {
        sector_t         sector;
        logic            neg;
        logic            achrom;
        logic            black;
        logic [CH_W-1:0] value;
    } side_t;

    typedef struct packed {
        logic [NUM_W-1:0] hue_num;
        logic [NUM_W-1:0] sat_num;
        logic [CH_W-1:0]  delta;
        side_t            side;
    } p3_t;

    logic [NST-1:0] valid_reg;
    logic [NST-1:0] valid_next;
    logic [NST:0]   adv;

    p1_t   p1_reg, p1_next;
    p2_t   p2_reg, p2_next;
    p3_t   p3_reg, p3_next;
    side_t side_reg[DIV_STAGES];
    rgbhsv_pkg::hsv_t out_reg, out_next;

    logic [QUO_W-1:0] hue_q;
    logic [QUO_W-1:0] sat_q;

    // A stage may load when it is empty or its content moves on this cycle.
    always_comb
    begin
        adv[NST] = hsv_ready;
        for (int k = NST - 1; k >= 0; k--)
        begin
            adv[k] = !valid_reg[k] || adv[k+1];
        end
        valid_next[0] = pixel_valid;
        for (int k = 1; k < NST; k++)
        begin
            valid_next[k] = valid_reg[k-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < NST; k++)
            begin
                if (adv[k])
                begin
                    valid_reg[k] <= valid_next[k];
                end
            end
        end
    end

    // Stage 1: max, min, max channel and the operand pair of the hue difference.
    always_comb
    begin
        logic [CH_W-1:0] r, g, b;
        logic            r_top, g_top;
        r     = pixel.red_in;
        g     = pixel.green_in;
        b     = pixel.blue_in;
        r_top = (r >= g) && (r >= b);
        g_top = (g >= b);
        if (r_top)
        begin
            p1_next.mx     = r;
            p1_next.x      = g;
            p1_next.y      = b;
            p1_next.sector = SECT_RED;
        end
        else if (g_top)
        begin
            p1_next.mx     = g;
            p1_next.x      = b;
            p1_next.y      = r;
            p1_next.sector = SECT_GREEN;
        end
        else
        begin
            p1_next.mx     = b;
            p1_next.x      = r;
            p1_next.y      = g;
            p1_next.sector = SECT_BLUE;
        end
        if ((r <= g) && (r <= b))
        begin
            p1_next.mn = r;
        end
        else if (g <= b)
        begin
            p1_next.mn = g;
        end
        else
        begin
            p1_next.mn = b;
        end
    end

    // Stage 2: delta, sign/magnitude of the difference and the black flag.
    always_comb
    begin
        p2_next.delta  = p1_reg.mx - p1_reg.mn;
        p2_next.neg    = p1_reg.x < p1_reg.y;
        p2_next.mag    = p2_next.neg ? (p1_reg.y - p1_reg.x) : (p1_reg.x - p1_reg.y);
        p2_next.sector = p1_reg.sector;
        p2_next.mx     = p1_reg.mx;
        p2_next.black  = (p1_reg.mx == '0);
    end

    // Stage 3: scaled dividends and the achromatic flag.
    always_comb
    begin
        p3_next.hue_num     = NUM_W'(p2_reg.mag) * NUM_W'(rgbhsv_pkg::HUE_SIXTH);
        p3_next.sat_num     = NUM_W'(p2_reg.delta) * NUM_W'(rgbhsv_pkg::SAT_SCALE);
        p3_next.delta       = p2_reg.delta;
        p3_next.side.sector = p2_reg.sector;
        p3_next.side.neg    = p2_reg.neg;
        p3_next.side.achrom = (p2_reg.delta == '0);
        p3_next.side.black  = p2_reg.black;
        p3_next.side.value  = p2_reg.mx;
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            p1_reg <= p1_next;
        end
        if (adv[1])
        begin
            p2_reg <= p2_next;
        end
        if (adv[2])
        begin
            p3_reg <= p3_next;
        end
        for (int j = 0; j < DIV_STAGES; j++)
        begin
            if (adv[DIV_FIRST + j])
            begin
                side_reg[j] <= (j == 0) ? p3_reg.side : side_reg[(j == 0) ? 0 : j - 1];
            end
        end
        if (adv[OUT_ST])
        begin
            out_reg <= out_next;
        end
    end

    // Zero divisors (achromatic or black) give junk quotients; masked at the output.
    rgbhsv_div #(
        .QUO_W     (QUO_W),
        .DEN_W     (CH_W),
        .STEP_BITS (DIV_STEP_BITS)
    ) u_hue_div (
        .clk (clk),
        .en  (adv[DIV_FIRST +: DIV_STAGES]),
        .num (p3_reg.hue_num),
        .den (p3_reg.delta),
        .quo (hue_q)
    );

    rgbhsv_div #(
        .QUO_W     (QUO_W),
        .DEN_W     (CH_W),
        .STEP_BITS (DIV_STEP_BITS)
    ) u_sat_div (
        .clk (clk),
        .en  (adv[DIV_FIRST +: DIV_STAGES]),
        .num (p3_reg.sat_num),
        .den (p3_reg.side.value),
        .quo (sat_q)
    );

    // Output stage: sector offset, wrap of negative red hue folded into the base, zero divisor masking.
    always_comb
    begin
        side_t            s;
        logic [HUE_W-1:0] base;
        logic [HUE_W-1:0] q;
        s = side_reg[DIV_STAGES-1];
        q = HUE_W'(hue_q);
        case (s.sector)
            SECT_RED:   base = s.neg ? HUE_W'(rgbhsv_pkg::HUE_TURN) : '0;
            SECT_GREEN: base = HUE_W'(2 * rgbhsv_pkg::HUE_SIXTH);
            SECT_BLUE:  base = HUE_W'(4 * rgbhsv_pkg::HUE_SIXTH);
            default:    base = '0;
        endcase
        out_next.hue_out        = s.achrom ? '0 : (s.neg ? base - q : base + q);
        out_next.saturation_out = s.black ? '0 : sat_q[CH_W-1:0];
        out_next.value_out      = s.value;
    end

    assign pixel_ready = adv[0];
    assign hsv_valid   = valid_reg[OUT_ST];
    assign hsv         = out_reg;

    // An empty output register means every stage can move.
    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !hsv_valid |-> pixel_ready)
        else $error("pixel_ready low with an empty output stage");

    a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
        hsv_valid |-> (hsv.hue_out < HUE_W'(rgbhsv_pkg::HUE_TURN)))
        else $error("hue beyond a full turn");

    a_black: assert property (@(posedge clk) disable iff (!rst_n)
        (hsv_valid && (hsv.value_out == '0)) |->
            ((hsv.saturation_out == '0) && (hsv.hue_out == '0)))
        else $error("black pixel with nonzero hue or saturation");

    a_gray_hue: assert property (@(posedge clk) disable iff (!rst_n)
        (hsv_valid && (hsv.saturation_out == '0)) |-> (hsv.hue_out == '0))
        else $error("zero saturation with nonzero hue");

    // Output register holds while stalled: drop or repeat would show here.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (hsv_valid && !hsv_ready) |=> (hsv_valid && $stable(out_reg)))
        else $error("stalled result changed");

endmodule
